// ----- design/feeder_and_flywheel_sequencer_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the feeder and flywheel sequencer
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef FEEDER_AND_FLYWHEEL_SEQUENCER_UNIT_MACROS_SVH
`define FEEDER_AND_FLYWHEEL_SEQUENCER_UNIT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define FAFS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fafs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define FAFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fafs assertion failed");

`endif

// ----- design/fafs_pkg.sv -----
// ----------------------------------------------------------------------------
// fafs_pkg
// Types, codes and helper functions of the feeder and flywheel sequencer.
// ----------------------------------------------------------------------------
package fafs_pkg;

  // control mode codes
  typedef enum logic [1:0] {
    CM_REMOTE = 2'd0,
    CM_AUTO   = 2'd1,
    CM_PC     = 2'd2,
    CM_LOST   = 2'd3
  } ctrl_mode_t;

  // fire mode codes; code 3 is unused
  typedef enum logic [1:0] {
    FM_SINGLE = 2'd0,
    FM_BURST  = 2'd1,
    FM_STOP   = 2'd2
  } fire_mode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SINGLE_STEP   = 3'd0,
    REG_BURST_STEP    = 3'd1,
    REG_SHOT_INTERVAL = 3'd2,
    REG_LEFT_SPEED    = 3'd3,
    REG_RIGHT_SPEED   = 3'd4,
    REG_DECAY_COEF    = 3'd5
  } reg_idx_t;

  localparam logic [15:0] SINGLE_STEP_RST   = 16'd2500;
  localparam logic [15:0] BURST_STEP_RST    = 16'd10000;
  localparam logic [15:0] SHOT_INTERVAL_RST = 16'd1;
  localparam logic [15:0] LEFT_SPEED_RST    = 16'hE4A8;  // -7000
  localparam logic [15:0] RIGHT_SPEED_RST   = 16'hE4A8;  // -7000
  localparam logic [15:0] DECAY_COEF_RST    = 16'd65209; // about 0.995 in Q0.16

  localparam logic [15:0] CNT_MAX   = 16'hFFFF;
  localparam logic [15:0] S16_MIN   = 16'h8000;
  localparam logic [15:0] S16_MAX   = 16'h7FFF;

  typedef struct packed {
    logic [15:0] single_step;
    logic [15:0] burst_step;
    logic [15:0] shot_interval;
    logic [15:0] left_speed;
    logic [15:0] right_speed;
    logic [15:0] decay_coef;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  arm_switch;
    logic [1:0]  control_mode;
    logic [1:0]  fire_mode;
    logic        mouse_left;
    logic        feeder_offline;
    logic [31:0] feeder_angle;
  } item_t;

  typedef struct packed {
    logic        primed;
    logic [15:0] shot_counter;
    logic [31:0] feeder_target;
    logic [15:0] left_last;
    logic [15:0] right_last;
    logic        firing_flag;
  } state_t;

  // input stage to top-level handshake status
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

  // v * coef / 65536, magnitude truncated toward zero
  function automatic logic [15:0] wheel_decay(input logic [15:0] v,
                                              input logic [15:0] coef);
    logic        neg;
    logic [16:0] mag;
    logic [32:0] prod;
    logic [15:0] r;
    neg  = v[15];
    mag  = neg ? (17'd0 - {v[15], v}) : {1'b0, v};
    prod = {16'd0, mag} * {17'd0, coef};
    r    = prod[31:16];
    return neg ? (16'd0 - r) : r;
  endfunction

  // negated left speed, most negative value saturates
  function automatic logic [15:0] spin_left(input logic [15:0] speed);
    return (speed == S16_MIN) ? S16_MAX : (16'd0 - speed);
  endfunction

endpackage

// ----- design/fafs_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// fafs_cfg_regs
// Configuration register file with its write channel.
// ----------------------------------------------------------------------------
module fafs_cfg_regs
  import fafs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.single_step   <= SINGLE_STEP_RST;
      cfg.burst_step    <= BURST_STEP_RST;
      cfg.shot_interval <= SHOT_INTERVAL_RST;
      cfg.left_speed    <= LEFT_SPEED_RST;
      cfg.right_speed   <= RIGHT_SPEED_RST;
      cfg.decay_coef    <= DECAY_COEF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SINGLE_STEP:   cfg.single_step   <= cfg_data;
        REG_BURST_STEP:    cfg.burst_step    <= cfg_data;
        REG_SHOT_INTERVAL: cfg.shot_interval <= cfg_data;
        REG_LEFT_SPEED:    cfg.left_speed    <= cfg_data;
        REG_RIGHT_SPEED:   cfg.right_speed   <= cfg_data;
        REG_DECAY_COEF:    cfg.decay_coef    <= cfg_data;
        default: ;  // writes past the list are dropped
      endcase
    end
  end

endmodule

// ----- design/fafs_in_reg.sv -----
// ----------------------------------------------------------------------------
// fafs_in_reg
// Input register; holds one tick until the result register can take it.
// ----------------------------------------------------------------------------
module fafs_in_reg
  import fafs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  item_t      in_item,
  input  logic       sink_free,
  output stage_ctl_t ctl,
  output item_t      item
);

  logic valid;

  assign ctl.valid   = valid;
  assign ctl.advance = valid && sink_free;
  assign in_ready    = !valid || sink_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ----- design/fafs_tick.sv -----
// ----------------------------------------------------------------------------
// fafs_tick
// Next-state logic for one control tick: feeder target, counter, wheels.
// ----------------------------------------------------------------------------
module fafs_tick
  import fafs_pkg::*;
(
  input  cfg_t   cfg,
  input  item_t  item,
  input  state_t cur,
  output state_t nxt
);

  logic [15:0] left_decay;
  logic [15:0] right_decay;
  logic [15:0] left_spin;
  logic        armed;
  logic        remote_auto;

  assign left_decay  = wheel_decay(cur.left_last, cfg.decay_coef);
  assign right_decay = wheel_decay(cur.right_last, cfg.decay_coef);
  assign left_spin   = spin_left(cfg.left_speed);
  // arm switch positions 1 and 3 both have bit 0 set
  assign armed       = item.arm_switch[0];
  assign remote_auto = (item.control_mode == CM_REMOTE) || (item.control_mode == CM_AUTO);

  always_comb begin
    nxt        = cur;
    nxt.primed = 1'b1;
    if (!cur.primed) begin
      nxt.feeder_target = item.feeder_angle;
    end
    if (item.feeder_offline) begin
      nxt.feeder_target = item.feeder_angle;
      nxt.firing_flag   = 1'b0;
    end
    if (armed && remote_auto) begin
      if ((cur.shot_counter > cfg.shot_interval) && (item.fire_mode == FM_SINGLE)) begin
        nxt.shot_counter = 16'd1;  // cleared, then counted for this tick
        if (!item.feeder_offline) begin
          nxt.feeder_target = nxt.feeder_target + {16'd0, cfg.single_step};
          nxt.firing_flag   = 1'b1;
        end
      end else begin
        if (cur.shot_counter != CNT_MAX) begin
          nxt.shot_counter = cur.shot_counter + 16'd1;
        end
        if (item.fire_mode == FM_BURST) begin
          if (!item.feeder_offline) begin
            nxt.feeder_target = nxt.feeder_target + {16'd0, cfg.burst_step};
            nxt.firing_flag   = 1'b1;
          end
        end else if (item.fire_mode == FM_STOP) begin
          nxt.firing_flag = 1'b0;
        end
      end
      if ((item.fire_mode == FM_SINGLE) || (item.fire_mode == FM_BURST)) begin
        nxt.left_last  = left_spin;
        nxt.right_last = cfg.right_speed;
      end else begin
        nxt.left_last  = left_decay;
        nxt.right_last = right_decay;
      end
    end
    if (armed && (item.control_mode == CM_PC)) begin
      if (item.mouse_left) begin
        if (!item.feeder_offline) begin
          nxt.feeder_target = nxt.feeder_target + {16'd0, cfg.burst_step};
          nxt.firing_flag   = 1'b1;
        end
        nxt.left_last  = left_spin;
        nxt.right_last = cfg.right_speed;
      end else begin
        nxt.firing_flag = 1'b0;
        nxt.left_last   = left_decay;
        nxt.right_last  = right_decay;
      end
    end
    // lost mode applies whatever the arm switch reads
    if (item.control_mode == CM_LOST) begin
      nxt.feeder_target = item.feeder_angle;
      nxt.left_last     = left_decay;
      nxt.right_last    = right_decay;
    end
  end

endmodule

// ----- design/feeder_and_flywheel_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// feeder_and_flywheel_sequencer_unit
// Per-tick feeder position and flywheel speed sequencer, top level.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  in       | input     | in_valid / in_ready  | arm_switch .. feeder_angle
//  out      | output    | out_valid / out_ready| feeder_setpoint .. firing
//  cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data (16 bits)
//
//  One transaction per cycle while out_ready stays high; an in transaction reaches
//  out_valid through the input register, then the state/result register.
//  The tick logic sits between the input register and the state registers,
//  which are also the result register, so each tick sees the previous one.
//  Reset (rst, synchronous) clears all state and loads the register defaults.
//  A stalled out channel holds the result and backs up into the input stage;
//  one more transaction is taken while a result waits.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "feeder_and_flywheel_sequencer_unit_macros.svh"

module feeder_and_flywheel_sequencer_unit
  import fafs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input transactions
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         arm_switch,
  input  logic [1:0]         control_mode,
  input  logic [1:0]         fire_mode,
  input  logic               mouse_left,
  input  logic               feeder_offline,
  input  logic signed [31:0] feeder_angle,
  // result transactions
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] feeder_setpoint,
  output logic signed [15:0] left_wheel_setpoint,
  output logic signed [15:0] right_wheel_setpoint,
  output logic               firing,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t       cfg;
  item_t      in_item;
  item_t      item;
  stage_ctl_t stage;
  state_t     st;
  state_t     st_next;
  logic       sink_free;

  assign in_item.arm_switch     = arm_switch;
  assign in_item.control_mode   = control_mode;
  assign in_item.fire_mode      = fire_mode;
  assign in_item.mouse_left     = mouse_left;
  assign in_item.feeder_offline = feeder_offline;
  assign in_item.feeder_angle   = feeder_angle;

  // result register is free when empty or being drained this cycle
  assign sink_free = !out_valid || out_ready;

  fafs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fafs_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .sink_free (sink_free),
    .ctl       (stage),
    .item      (item)
  );

  fafs_tick u_tick (
    .cfg  (cfg),
    .item (item),
    .cur  (st),
    .nxt  (st_next)
  );

  // state advances exactly once per tick; the new state is the result
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (stage.advance) begin
        st        <= st_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign feeder_setpoint      = st.feeder_target;
  assign left_wheel_setpoint  = st.left_last;
  assign right_wheel_setpoint = st.right_last;
  assign firing               = st.firing_flag;

  // any processed tick leaves the target seeded
  `FAFS_ASSERT_NEXT(a_primed_after_tick, stage.advance, st.primed)
  // an offline feeder never reports firing
  `FAFS_ASSERT_NEXT(a_offline_not_firing, stage.advance && item.feeder_offline, !firing)
  // lost mode tracks the measured angle
  `FAFS_ASSERT_NEXT(a_lost_tracks_angle, stage.advance && (item.control_mode == CM_LOST), feeder_setpoint == $past(item.feeder_angle))
  // a held tick is not dropped
  `FAFS_ASSERT_NEXT(a_stage_holds, stage.valid && !stage.advance, stage.valid)

endmodule
